### rtl/sfrt_pkg.sv
// shared types and constants for the swap frame replacement table
package sfrt_pkg;

  // fixed field widths
  localparam int PAGE_W  = 20;
  localparam int OWNER_W = 4;
  localparam int FRAME_W = 4;
  localparam int BLOCK_W = 5;

  // default sizing
  localparam int DEF_FRAME_COUNT     = 16;
  localparam int DEF_PAGES_PER_SPACE = 32;

  // action codes
  localparam logic ACT_FAULT   = 1'b0;
  localparam logic ACT_RELEASE = 1'b1;

  // controller to datapath commands
  typedef struct packed {
    logic load;         // capture the beat, restart scan and block reduction
    logic scan_step;    // move to next frame of the free-frame scan
    logic pick_empty;   // take the frame under the scan index
    logic pick_rotate;  // step the round-robin pointer and take its frame
    logic rd_pick;      // read table entry of the chosen frame
    logic rd_scan;      // read table entry under the scan index, step index
    logic put;          // record the new owner and present the result
  } cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic empty_here;   // frame under the scan index is empty
    logic scan_last;    // scan index is on the last frame
    logic mod_done;     // block reduction of the page has finished
  } stat_t;

endpackage

### rtl/sfrt_ctrl.sv
// sequencer for fault placement and owner release
module sfrt_ctrl import sfrt_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  start,
  input  logic  action,
  input  stat_t stat,
  output logic  busy,
  output cmd_t  cmd
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_FSCAN  = 3'd1;
  localparam logic [2:0] S_FWAIT  = 3'd2;
  localparam logic [2:0] S_FPUT   = 3'd3;
  localparam logic [2:0] S_RSCAN  = 3'd4;
  localparam logic [2:0] S_RDRAIN = 3'd5;

  logic [2:0] state;
  logic [2:0] state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    cmd        = '0;
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (start) begin
          cmd.load   = 1'b1;
          state_next = (action == ACT_RELEASE) ? S_RSCAN : S_FSCAN;
        end
      end
      S_FSCAN: begin
        if (stat.empty_here) begin
          cmd.pick_empty = 1'b1;
          state_next     = S_FWAIT;
        end else if (stat.scan_last) begin
          cmd.pick_rotate = 1'b1;
          state_next      = S_FWAIT;
        end else begin
          cmd.scan_step = 1'b1;
        end
      end
      S_FWAIT: begin
        if (stat.mod_done) begin
          cmd.rd_pick = 1'b1;
          state_next  = S_FPUT;
        end
      end
      S_FPUT: begin
        cmd.put    = 1'b1;
        state_next = S_IDLE;
      end
      S_RSCAN: begin
        cmd.rd_scan = 1'b1;
        if (stat.scan_last) begin
          state_next = S_RDRAIN;
        end
      end
      S_RDRAIN: begin
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  assign busy = (state != S_IDLE);

endmodule

### rtl/sfrt_datapath.sv
// frame table, scan index, round-robin pointer and block reduction
module sfrt_datapath import sfrt_pkg::*; #(
  parameter int FRAME_COUNT     = DEF_FRAME_COUNT,
  parameter int PAGES_PER_SPACE = DEF_PAGES_PER_SPACE
) (
  input  logic               clk,
  input  logic               rst,
  input  logic [OWNER_W-1:0] owner_id,
  input  logic [PAGE_W-1:0]  page_number,
  input  cmd_t               cmd,
  output stat_t              stat,
  output logic [FRAME_W-1:0] frame,
  output logic               evict,
  output logic [OWNER_W-1:0] old_owner,
  output logic [BLOCK_W-1:0] old_block,
  output logic [BLOCK_W-1:0] new_block,
  output logic               done
);

  localparam int FIDX_W = $clog2(FRAME_COUNT);
  localparam int BLK_W  = $clog2(PAGES_PER_SPACE);
  localparam int FEXT_W = (FIDX_W > FRAME_W) ? FIDX_W : FRAME_W;
  localparam int BEXT_W = (BLK_W > BLOCK_W) ? BLK_W : BLOCK_W;
  localparam int PROD_W = 2 * PAGE_W + 1;
  localparam int RSH    = PAGE_W + BLK_W;
  localparam longint RECIP_L =
    ((longint'(1) << RSH) + longint'(PAGES_PER_SPACE) - 1) / longint'(PAGES_PER_SPACE);
  localparam logic [FIDX_W-1:0] LAST_FRAME = FIDX_W'(FRAME_COUNT - 1);
  localparam logic [BLK_W:0]    MODULUS    = (BLK_W + 1)'(PAGES_PER_SPACE);
  localparam logic [PAGE_W:0]   RECIP      = (PAGE_W + 1)'(RECIP_L);

  // block reduction steps
  localparam logic [1:0] M_MUL  = 2'd0;
  localparam logic [1:0] M_QM   = 2'd1;
  localparam logic [1:0] M_SUB  = 2'd2;
  localparam logic [1:0] M_DONE = 2'd3;

  // table
  logic [FRAME_COUNT-1:0] used;
  logic [OWNER_W-1:0]     owner_mem [FRAME_COUNT];
  logic [BLK_W-1:0]       blk_mem   [FRAME_COUNT];

  logic [OWNER_W-1:0] owner_r;
  logic [PAGE_W-1:0]  page_r;
  logic [BLK_W-1:0]   rem;
  logic [1:0]         mstage;
  logic [FIDX_W-1:0]  idx;
  logic [FIDX_W-1:0]  pick;
  logic [FIDX_W-1:0]  rot;
  logic [FIDX_W-1:0]  rot_next;
  logic [FIDX_W-1:0]  rd_addr;
  logic [OWNER_W-1:0] owner_q;
  logic [BLK_W-1:0]   blk_q;
  logic               used_q;
  logic               cmp_vld;
  logic [FIDX_W-1:0]  cmp_idx;

  logic [PROD_W-1:0]       prod;
  logic [PROD_W-1:0]       prod_full;
  logic [PAGE_W-1:0]       quot;
  logic [PAGE_W+BLK_W:0]   qm_full;
  logic [PAGE_W-1:0]       qm;
  logic [PAGE_W-1:0]       diff;
  logic                    mod_busy;
  logic [FEXT_W-1:0]       pick_ext;
  logic [BEXT_W-1:0]       rem_ext;
  logic [BEXT_W-1:0]       blk_q_ext;

  // block = page - (page * RECIP >> RSH) * PAGES_PER_SPACE, one step per cycle
  // the rounded-up reciprocal gives the exact quotient for every 20-bit page
  assign prod_full = {{(PAGE_W + 1){1'b0}}, page_r} * {{PAGE_W{1'b0}}, RECIP};
  assign quot      = PAGE_W'(prod >> RSH);
  assign qm_full   = {{(BLK_W + 1){1'b0}}, quot} * {{PAGE_W{1'b0}}, MODULUS};
  assign diff      = page_r - qm;
  assign mod_busy  = (mstage != M_DONE);

  assign rot_next = (rot == LAST_FRAME) ? '0 : (rot + 1'b1);
  assign rd_addr  = cmd.rd_scan ? idx : pick;

  assign pick_ext  = FEXT_W'(pick);
  assign rem_ext   = BEXT_W'(rem);
  assign blk_q_ext = BEXT_W'(blk_q);

  assign stat.empty_here = !used[idx];
  assign stat.scan_last  = (idx == LAST_FRAME);
  assign stat.mod_done   = !mod_busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      mstage  <= M_DONE;
      rem     <= '0;
      idx     <= '0;
      rot     <= '0;
      cmp_vld <= 1'b0;
      done    <= 1'b0;
      used    <= '0;
    end else begin
      done    <= cmd.put;
      cmp_vld <= cmd.rd_scan;
      if (cmd.load) begin
        mstage <= M_MUL;
        rem    <= '0;
        idx    <= '0;
      end else begin
        if (mod_busy) begin
          mstage <= mstage + 1'b1;
          if (mstage == M_SUB) begin
            rem <= diff[BLK_W-1:0];
          end
        end
        if (cmd.scan_step || cmd.rd_scan) begin
          idx <= idx + 1'b1;
        end
      end
      if (cmd.pick_empty) begin
        rot <= idx;
      end else if (cmd.pick_rotate) begin
        rot <= rot_next;
      end
      if (cmd.put) begin
        used[pick] <= 1'b1;
      end
      if (cmp_vld && used[cmp_idx] && (owner_q == owner_r)) begin
        used[cmp_idx] <= 1'b0;
      end
    end
  end

  // beat capture, reduction pipeline and choice of frame
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      owner_r <= owner_id;
      page_r  <= page_number;
    end
    prod <= prod_full;
    qm   <= qm_full[PAGE_W-1:0];
    if (cmd.pick_empty) begin
      pick <= idx;
    end else if (cmd.pick_rotate) begin
      pick <= rot_next;
    end
    if (cmd.rd_pick) begin
      used_q <= used[pick];
    end
    cmp_idx <= idx;
  end

  // owner and block memory, one write and one registered read
  always_ff @(posedge clk) begin
    if (cmd.put) begin
      owner_mem[pick] <= owner_r;
      blk_mem[pick]   <= rem;
    end
    if (cmd.rd_pick || cmd.rd_scan) begin
      owner_q <= owner_mem[rd_addr];
      blk_q   <= blk_mem[rd_addr];
    end
  end

  // result registers
  always_ff @(posedge clk) begin
    if (cmd.put) begin
      frame     <= pick_ext[FRAME_W-1:0];
      evict     <= used_q;
      old_owner <= used_q ? owner_q : '0;
      old_block <= used_q ? blk_q_ext[BLOCK_W-1:0] : '0;
      new_block <= rem_ext[BLOCK_W-1:0];
    end
  end

`ifndef SYNTH
  a_done_single: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("result strobe held for more than one cycle");

  a_no_evict_zero: assert property (@(posedge clk) disable iff (rst)
    (done && !evict) |-> (old_owner == '0 && old_block == '0))
    else $error("victim fields not zero without eviction");

  a_put_marks_used: assert property (@(posedge clk) disable iff (rst)
    cmd.put |=> used[pick])
    else $error("placed frame not marked used");

  a_rem_bound: assert property (@(posedge clk) disable iff (rst)
    {1'b0, rem} < MODULUS)
    else $error("block remainder out of range");

  a_put_after_reduction: assert property (@(posedge clk) disable iff (rst)
    cmd.put |-> !mod_busy)
    else $error("result presented before block reduction finished");
`endif

endmodule

### rtl/swap_frame_replacement_table.sv
// top level of the swap frame replacement table
//
//   channel  | handshake              | beat fields
//   ---------+------------------------+-------------------------------------
//   command  | start, busy            | action, owner_id, page_number
//   result   | done (one-cycle pulse) | frame, evict, old_owner, old_block,
//            |                        | new_block
//
// a beat is taken at a rising edge with start high and busy low
// a fault beat is busy while the free-frame scan over the used bits runs, one frame per
// cycle, and until the three-step block reduction of the page, run alongside, has
// finished; done comes in the cycle after busy ends
// a release beat is busy while it reads the table once per frame and compares each owner
// rst clears the used bits, the round-robin pointer and the sequencer
// results cannot be stalled: done marks a beat valid for that one cycle
module swap_frame_replacement_table import sfrt_pkg::*; #(
  parameter int FRAME_COUNT     = DEF_FRAME_COUNT,
  parameter int PAGES_PER_SPACE = DEF_PAGES_PER_SPACE
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic               action,
  input  logic [OWNER_W-1:0] owner_id,
  input  logic [PAGE_W-1:0]  page_number,
  output logic               done,
  output logic [FRAME_W-1:0] frame,
  output logic               evict,
  output logic [OWNER_W-1:0] old_owner,
  output logic [BLOCK_W-1:0] old_block,
  output logic [BLOCK_W-1:0] new_block
);

  cmd_t  cmd;
  stat_t stat;

  // sequencer: scan, pick, read victim, record and report, or scan and release an owner
  sfrt_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .action (action),
    .stat   (stat),
    .busy   (busy),
    .cmd    (cmd)
  );

  // frame table and arithmetic
  sfrt_datapath #(
    .FRAME_COUNT     (FRAME_COUNT),
    .PAGES_PER_SPACE (PAGES_PER_SPACE)
  ) u_datapath (
    .clk         (clk),
    .rst         (rst),
    .owner_id    (owner_id),
    .page_number (page_number),
    .cmd         (cmd),
    .stat        (stat),
    .frame       (frame),
    .evict       (evict),
    .old_owner   (old_owner),
    .old_block   (old_block),
    .new_block   (new_block),
    .done        (done)
  );

endmodule

### sim/swap_frame_replacement_table_test.sv
// testbench for the swap frame replacement table: directed and random faults and releases
`timescale 1ns / 1ps

import sfrt_pkg::*;

// one placement the table is expected to report for a fault beat
typedef struct {
  logic [FRAME_W-1:0] frame;
  logic               evict;
  logic [OWNER_W-1:0] old_owner;
  logic [BLOCK_W-1:0] old_block;
  logic [BLOCK_W-1:0] new_block;
} placement_t;

// shadow frame table plus the queue of placements still owed by the block
class frame_table_scoreboard;
  bit                 held   [DEF_FRAME_COUNT];
  logic [OWNER_W-1:0] holder [DEF_FRAME_COUNT];
  logic [PAGE_W-1:0]  vpage  [DEF_FRAME_COUNT];
  int unsigned        rr_ptr;
  placement_t         owed_placements[$];
  int unsigned        mismatches;

  function new();
    for (int k = 0; k < DEF_FRAME_COUNT; k++) begin
      held[k]   = 1'b0;
      holder[k] = '0;
      vpage[k]  = '0;
    end
    rr_ptr     = 0;
    mismatches = 0;
  endfunction

  task report_mismatch(string what);
    mismatches++;
    $display("%0t mismatch: %s", $realtime, what);
  endtask

  // update the shadow table for an accepted beat, queue the placement of a fault
  function void note_command(logic act, logic [OWNER_W-1:0] own, logic [PAGE_W-1:0] pg);
    placement_t p;
    int         f;
    bit         found;
    if (act == ACT_RELEASE) begin
      for (int k = 0; k < DEF_FRAME_COUNT; k++)
        if (held[k] && holder[k] == own) held[k] = 1'b0;
      return;
    end
    found = 1'b0;
    f     = 0;
    for (int k = 0; k < DEF_FRAME_COUNT; k++) begin
      if (!found && !held[k]) begin
        found = 1'b1;
        f     = k;
      end
    end
    if (found) begin
      rr_ptr = f;
    end else begin
      rr_ptr = (rr_ptr + 1) % DEF_FRAME_COUNT;
      f      = rr_ptr;
    end
    p.frame = FRAME_W'(f);
    p.evict = held[f];
    if (held[f]) begin
      p.old_owner = holder[f];
      p.old_block = BLOCK_W'(vpage[f] % DEF_PAGES_PER_SPACE);
    end else begin
      p.old_owner = '0;
      p.old_block = '0;
    end
    p.new_block = BLOCK_W'(pg % DEF_PAGES_PER_SPACE);
    owed_placements.push_back(p);
    held[f]   = 1'b1;
    holder[f] = own;
    vpage[f]  = pg;
  endfunction

  task check_placement(placement_t got);
    placement_t want;
    string      diffs;
    if (owed_placements.size() == 0) begin
      report_mismatch($sformatf("result on frame %0d with nothing owed", got.frame));
      return;
    end
    want  = owed_placements.pop_front();
    diffs = "";
    if (got.frame !== want.frame)
      diffs = {diffs, $sformatf(" frame %0d/%0d", got.frame, want.frame)};
    if (got.evict !== want.evict)
      diffs = {diffs, $sformatf(" evict %0b/%0b", got.evict, want.evict)};
    if (got.old_owner !== want.old_owner)
      diffs = {diffs, $sformatf(" old_owner %0d/%0d", got.old_owner, want.old_owner)};
    if (got.old_block !== want.old_block)
      diffs = {diffs, $sformatf(" old_block %0d/%0d", got.old_block, want.old_block)};
    if (got.new_block !== want.new_block)
      diffs = {diffs, $sformatf(" new_block %0d/%0d", got.new_block, want.new_block)};
    if (diffs != "") report_mismatch({"got/want:", diffs});
  endtask
endclass

module swap_frame_replacement_table_test;

  // every input starts at a known value, reset held from time zero
  logic               clk         = 1'b0;
  logic               rst         = 1'b1;
  logic               start       = 1'b0;
  logic               action      = ACT_FAULT;
  logic [OWNER_W-1:0] owner_id    = '0;
  logic [PAGE_W-1:0]  page_number = '0;
  logic               busy;
  logic               done;
  logic [FRAME_W-1:0] frame;
  logic               evict;
  logic [OWNER_W-1:0] old_owner;
  logic [BLOCK_W-1:0] old_block;
  logic [BLOCK_W-1:0] new_block;

  frame_table_scoreboard board = new();

  // when set, beats follow each other with no idle cycles in between
  bit steady_feed = 1'b0;

  swap_frame_replacement_table i_dut (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .busy        (busy),
    .action      (action),
    .owner_id    (owner_id),
    .page_number (page_number),
    .done        (done),
    .frame       (frame),
    .evict       (evict),
    .old_owner   (old_owner),
    .old_block   (old_block),
    .new_block   (new_block)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // results cannot be held off, so every done cycle is taken at the edge that ends it;
  // reading in the active region sees the values from before that edge
  always @(posedge clk) begin
    placement_t got;
    if (!rst && done) begin
      got.frame     = frame;
      got.evict     = evict;
      got.old_owner = old_owner;
      got.old_block = old_block;
      got.new_block = new_block;
      board.check_placement(got);
    end
  end

  // present one command beat and wait for the edge that takes it
  // start is left high afterwards: the next call lowers it only if it idles first,
  // so start never gets two assignments in one time step
  task automatic send_command(logic act, logic [OWNER_W-1:0] own, logic [PAGE_W-1:0] pg);
    int unsigned gap;
    gap = steady_feed ? 0 : $urandom_range(0, 4);
    if (gap != 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start       <= 1'b1;
    action      <= act;
    owner_id    <= own;
    page_number <= pg;
    // busy sampled here is the value the block saw at this edge
    do @(posedge clk); while (busy);
    board.note_command(act, own, pg);
  endtask

  initial begin
    int unsigned        k;
    int unsigned        pick;
    logic [OWNER_W-1:0] own;
    logic [PAGE_W-1:0]  pg;

    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // fill every frame from empty, one owner per frame, owner 0 and 15 included,
    // pages from all zeros to all ones
    for (k = 0; k < DEF_FRAME_COUNT; k++) begin
      if (k == 0)      pg = '0;
      else if (k == 1) pg = '1;
      else             pg = PAGE_W'(k * 65537 + k);
      send_command(ACT_FAULT, OWNER_W'(k), pg);
    end
    // table full: round robin steps on from the last empty pick, evicting owner 0 on the way
    send_command(ACT_FAULT, 4'd1, 20'h0001f);
    send_command(ACT_FAULT, 4'd8, 20'h00020);
    // release a holder, then the same owner again with nothing left to free
    send_command(ACT_RELEASE, 4'd5, 20'hfffff);
    send_command(ACT_RELEASE, 4'd5, '0);
    // owner 0 lost its only frame to the eviction above
    send_command(ACT_RELEASE, 4'd0, 20'h12345);
    // the freed frame is refilled first, then round robin resumes after it
    send_command(ACT_FAULT, 4'd15, 20'h80000);
    send_command(ACT_FAULT, 4'd9, 20'h7ffff);

    // random part: mostly faults from the usual owners so the table runs full and
    // wraps often, releases now and then, odd owner ids and small pages mixed in
    for (k = 0; k < 400; k++) begin
      steady_feed = (k % 80) < 20;
      pick        = $urandom_range(0, 99);
      if (pick < 14) begin
        own = (pick < 11) ? OWNER_W'($urandom_range(1, 8)) : OWNER_W'($urandom_range(0, 15));
        send_command(ACT_RELEASE, own, PAGE_W'($urandom()));
      end else begin
        own = (pick < 90) ? OWNER_W'($urandom_range(1, 8)) : OWNER_W'($urandom_range(0, 15));
        pg  = (pick % 3 == 0) ? PAGE_W'($urandom_range(0, 63)) : PAGE_W'($urandom());
        send_command(ACT_FAULT, own, pg);
      end
    end
    start <= 1'b0;

    // drain outstanding placements, then allow for a trailing release beat
    while (board.owed_placements.size() != 0) @(posedge clk);
    repeat (DEF_FRAME_COUNT + 24) @(posedge clk);

    if (board.mismatches == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  // watchdog: far beyond the slowest correct run
  initial begin
    #2_000_000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule

### filelist.f
rtl/sfrt_pkg.sv
rtl/sfrt_ctrl.sv
rtl/sfrt_datapath.sv
rtl/swap_frame_replacement_table.sv
sim/swap_frame_replacement_table_test.sv
